### hw/rtl/deadline_work_admission_assert.svh
// Assertion macros for the deadline work admission block.
// Used by the top level only; relies on nothing else.
`ifndef DEADLINE_WORK_ADMISSION_ASSERT_SVH
`define DEADLINE_WORK_ADMISSION_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define DWA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dwa: assertion failed");

// Next-cycle implication, disabled in reset.
`define DWA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dwa: assertion failed");

`endif

### hw/rtl/dwa_pkg.sv
// Types, constants and class tables for the deadline work admission block.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dwa_pkg;

  localparam int unsigned QuietW  = 40;
  localparam int unsigned BudgetW = 23;
  localparam int unsigned BlocksW = 9;
  localparam int unsigned FloorW  = 25;

  localparam logic [QuietW-1:0] QuietReset     = 40'd50_000_000;
  localparam logic [63:0]       MarginNs       = 64'd250_000;
  localparam logic [BudgetW-1:0] MinUsefulNs   = 23'd100_000;
  localparam logic [62:0]       DisplayQuietNs = 63'd100_000_000;
  localparam logic [62:0]       GuestQuietNs   = 63'd20_000_000;

  typedef enum logic [2:0] {
    CLS_ACT_NATIVE   = 3'd0,
    CLS_INTERACTIVE  = 3'd1,
    CLS_ACT_PORTABLE = 3'd2,
    CLS_PREDICTIVE   = 3'd3,
    CLS_OFFLINE      = 3'd4
  } cls_t;

  typedef enum logic [2:0] {
    VERDICT_GRANTED  = 3'd0,
    VERDICT_MEMORY   = 3'd1,
    VERDICT_GUEST    = 3'd2,
    VERDICT_DISPLAY  = 3'd3,
    VERDICT_DEADLINE = 3'd4,
    VERDICT_ZERO     = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [2:0]  command;
    logic        mem_pressure;
    logic [63:0] compile_p95_ns;
    logic [63:0] compile_p99_ns;
    logic        realtime_pending;
    logic        interaction_quiet_valid;
    logic [62:0] interaction_quiet_ns;
    logic        display_live;
    logic [62:0] display_quiet_ns;
    logic [62:0] guest_idle_ns;
    logic        deadline_valid;
    logic signed [63:0] deadline_left_ns;
  } req_t;

  function automatic cls_t cls_of(input logic [2:0] command);
    cls_t c;
    case (command)
      3'd0:    c = CLS_ACT_NATIVE;
      3'd1:    c = CLS_INTERACTIVE;
      3'd2:    c = CLS_ACT_PORTABLE;
      3'd3:    c = CLS_PREDICTIVE;
      default: c = CLS_OFFLINE;
    endcase
    return c;
  endfunction

  function automatic logic [BudgetW-1:0] cls_budget(input cls_t c);
    logic [BudgetW-1:0] b;
    case (c)
      CLS_ACT_NATIVE:   b = 23'd8_000_000;
      CLS_INTERACTIVE:  b = 23'd1_000_000;
      CLS_ACT_PORTABLE: b = 23'd8_000_000;
      CLS_PREDICTIVE:   b = 23'd2_000_000;
      default:          b = 23'd500_000;
    endcase
    return b;
  endfunction

  function automatic logic [FloorW-1:0] cls_floor(input cls_t c);
    logic [FloorW-1:0] f;
    case (c)
      CLS_OFFLINE: f = 25'd20_000_000;
      default:     f = 25'd500_000;
    endcase
    return f;
  endfunction

  function automatic logic [BlocksW-1:0] cls_blocks(input cls_t c);
    logic [BlocksW-1:0] n;
    case (c)
      CLS_ACT_NATIVE:   n = 9'd256;
      CLS_INTERACTIVE:  n = 9'd32;
      CLS_ACT_PORTABLE: n = 9'd256;
      CLS_PREDICTIVE:   n = 9'd64;
      default:          n = 9'd16;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] cls_shift(input cls_t c);
    logic [1:0] s;
    case (c)
      CLS_ACT_NATIVE:   s = 2'd1;
      CLS_ACT_PORTABLE: s = 2'd1;
      CLS_INTERACTIVE:  s = 2'd2;
      CLS_PREDICTIVE:   s = 2'd2;
      default:          s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/dwa_if.sv
// Request and response channel interfaces (valid/ready with payload).
// Depends on dwa_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dwa_req_if;
  import dwa_pkg::*;

  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic        mem_pressure;
  logic [63:0] compile_p95_ns;
  logic [63:0] compile_p99_ns;
  logic        realtime_pending;
  logic        interaction_quiet_valid;
  logic [62:0] interaction_quiet_ns;
  logic        display_live;
  logic [62:0] display_quiet_ns;
  logic [62:0] guest_idle_ns;
  logic        deadline_valid;
  logic signed [63:0] deadline_left_ns;

  modport source (
    output valid, command, mem_pressure, compile_p95_ns, compile_p99_ns,
           realtime_pending, interaction_quiet_valid, interaction_quiet_ns,
           display_live, display_quiet_ns, guest_idle_ns, deadline_valid,
           deadline_left_ns,
    input  ready
  );
  modport sink (
    input  valid, command, mem_pressure, compile_p95_ns, compile_p99_ns,
           realtime_pending, interaction_quiet_valid, interaction_quiet_ns,
           display_live, display_quiet_ns, guest_idle_ns, deadline_valid,
           deadline_left_ns,
    output ready
  );
endinterface

interface dwa_rsp_if;
  import dwa_pkg::*;

  logic               valid;
  logic               ready;
  logic [BudgetW-1:0] budget_ns;
  logic [BlocksW-1:0] block_limit;
  verdict_t           verdict;

  modport source (output valid, budget_ns, block_limit, verdict, input ready);
  modport sink   (input valid, budget_ns, block_limit, verdict, output ready);
endinterface

`default_nettype wire

### hw/rtl/deadline_work_admission.sv
// Deadline work admission: top level, four-stage decision pipeline.
// Depends on dwa_pkg, dwa_if.sv and deadline_work_admission_assert.svh.
//
// Usage:
//   req  - request item: work class and system observations.
//   rsp  - one response item per request: budget_ns, block_limit, verdict.
//   APB  - one 40-bit register, interactive_quiet_period_ns, at address 0
//          (64-bit data). Write only while no item is in flight.
// Register stages, in order: class checks and max of percentiles; reserve
//   sum and floor; deadline minus reserve; slack shift, clamp and verdict.
// Throughput: one item per cycle when no stall holds it; the pipeline has no loop.
// Reset: all valid bits clear, the quiet period returns to 50 ms.
// Stall: while rsp.ready is low and a response waits, every stage holds.
//   req.ready stays high for one more item, which parks in a skid
//   register; req.ready then drops until the pipeline moves again.
`timescale 1ns / 1ps
`default_nettype none
`include "deadline_work_admission_assert.svh"

module deadline_work_admission (
  input  wire logic                   clk,
  input  wire logic                   rst,
  dwa_req_if.sink                     req,
  dwa_rsp_if.source                   rsp,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [3:0]             paddr,
  input  wire logic [63:0]            pwdata,
  output      logic [63:0]            prdata,
  output      logic                   pready
);
  import dwa_pkg::*;

  // configuration
  logic [QuietW-1:0] quiet_period;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[3] == 1'b0);
  assign prdata    = (paddr[3] == 1'b0) ? {{(64-QuietW){1'b0}}, quiet_period} : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      quiet_period <= QuietReset;
    end else if (cfg_write) begin
      quiet_period <= pwdata[QuietW-1:0];
    end
  end

  // input skid and pipeline advance
  logic advance;
  logic skid_v;
  req_t skid;
  req_t in_item;
  req_t src;
  logic src_v;
  logic in_acc;

  always_comb begin
    in_item.command                 = req.command;
    in_item.mem_pressure            = req.mem_pressure;
    in_item.compile_p95_ns          = req.compile_p95_ns;
    in_item.compile_p99_ns          = req.compile_p99_ns;
    in_item.realtime_pending        = req.realtime_pending;
    in_item.interaction_quiet_valid = req.interaction_quiet_valid;
    in_item.interaction_quiet_ns    = req.interaction_quiet_ns;
    in_item.display_live            = req.display_live;
    in_item.display_quiet_ns        = req.display_quiet_ns;
    in_item.guest_idle_ns           = req.guest_idle_ns;
    in_item.deadline_valid          = req.deadline_valid;
    in_item.deadline_left_ns        = req.deadline_left_ns;
  end

  assign req.ready = !skid_v;
  assign in_acc    = req.valid && req.ready;
  assign advance   = !rsp.valid || rsp.ready;
  assign src       = skid_v ? skid : in_item;
  assign src_v     = skid_v || in_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (advance) begin
      skid_v <= 1'b0;
    end else if (in_acc) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!advance && in_acc) begin
      skid <= in_item;
    end
  end

  // stage 1: class, early refusals, worst percentile, clipped deadline
  cls_t     s1_cls_next;
  verdict_t s1_code_next;
  logic     s1_v;
  cls_t     s1_cls;
  verdict_t s1_code;
  logic [63:0] s1_worst;
  logic [62:0] s1_rem;
  logic        s1_dlv;

  always_comb begin
    s1_cls_next  = cls_of(src.command);
    s1_code_next = VERDICT_GRANTED;
    if (src.mem_pressure) begin
      s1_code_next = VERDICT_MEMORY;
    end else if (s1_cls_next == CLS_INTERACTIVE) begin
      if (src.realtime_pending || !src.interaction_quiet_valid ||
          src.interaction_quiet_ns < {{(63-QuietW){1'b0}}, quiet_period}) begin
        s1_code_next = VERDICT_GUEST;
      end
    end else if (s1_cls_next == CLS_OFFLINE) begin
      if (!src.display_live || src.display_quiet_ns < DisplayQuietNs) begin
        s1_code_next = VERDICT_DISPLAY;
      end else if (!src.deadline_valid && src.guest_idle_ns < GuestQuietNs) begin
        s1_code_next = VERDICT_GUEST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (advance) begin
      s1_v <= src_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cls   <= s1_cls_next;
      s1_code  <= s1_code_next;
      s1_worst <= (src.compile_p95_ns > src.compile_p99_ns) ?
                  src.compile_p95_ns : src.compile_p99_ns;
      s1_rem   <= src.deadline_left_ns[63] ? 63'd0 : src.deadline_left_ns[62:0];
      s1_dlv   <= src.deadline_valid;
    end
  end

  // stage 2: reserve = max(floor, sat(worst + margin))
  logic [64:0] s2_sum;
  logic [63:0] s2_sat;
  logic [63:0] s2_floor;
  logic        s2_v;
  cls_t        s2_cls;
  verdict_t    s2_code;
  logic [62:0] s2_rem;
  logic        s2_dlv;
  logic [63:0] s2_reserve;

  assign s2_sum   = {1'b0, s1_worst} + {1'b0, MarginNs};
  assign s2_sat   = s2_sum[64] ? {64{1'b1}} : s2_sum[63:0];
  assign s2_floor = {{(64-FloorW){1'b0}}, cls_floor(s1_cls)};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (advance) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_cls     <= s1_cls;
      s2_code    <= s1_code;
      s2_rem     <= s1_rem;
      s2_dlv     <= s1_dlv;
      s2_reserve <= (s2_sat < s2_floor) ? s2_floor : s2_sat;
    end
  end

  // stage 3: remaining minus reserve
  logic [64:0] s3_diff_next;
  logic        s3_v;
  cls_t        s3_cls;
  verdict_t    s3_code;
  logic        s3_dlv;
  logic        s3_within;
  logic [62:0] s3_diff;

  assign s3_diff_next = {2'b00, s2_rem} - {1'b0, s2_reserve};

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (advance) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_cls    <= s2_cls;
      s3_code   <= s2_code;
      s3_dlv    <= s2_dlv;
      // borrow or zero: remaining does not exceed the reserve
      s3_within <= s3_diff_next[64] || (s3_diff_next == 65'd0);
      s3_diff   <= s3_diff_next[62:0];
    end
  end

  // stage 4: slack, clamp and verdict into the output register
  logic [62:0]        slack;
  logic [BudgetW-1:0] base_budget;
  logic [BudgetW-1:0] budget;
  verdict_t           verdict_next;
  logic               out_v;
  logic [BudgetW-1:0] out_budget;
  logic [BlocksW-1:0] out_blocks;
  verdict_t           out_verdict;

  always_comb begin
    slack       = s3_diff >> cls_shift(s3_cls);
    base_budget = cls_budget(s3_cls);
    budget      = base_budget;
    if (s3_dlv && (slack < {{(63-BudgetW){1'b0}}, base_budget})) begin
      budget = slack[BudgetW-1:0];
    end
    if (s3_code != VERDICT_GRANTED) begin
      verdict_next = s3_code;
    end else if (s3_dlv && s3_within) begin
      verdict_next = VERDICT_DEADLINE;
    end else if (budget < MinUsefulNs) begin
      verdict_next = VERDICT_ZERO;
    end else begin
      verdict_next = VERDICT_GRANTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (advance) begin
      out_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_verdict <= verdict_next;
      out_budget  <= (verdict_next == VERDICT_GRANTED) ? budget : '0;
      out_blocks  <= (verdict_next == VERDICT_GRANTED) ? cls_blocks(s3_cls) : '0;
    end
  end

  assign rsp.valid       = out_v;
  assign rsp.budget_ns   = out_budget;
  assign rsp.block_limit = out_blocks;
  assign rsp.verdict     = out_verdict;

  // checks
  `DWA_ASSERT_NOW(a_refused_zero, clk, rst,
    rsp.valid && (rsp.verdict != VERDICT_GRANTED),
    (rsp.budget_ns == '0) && (rsp.block_limit == '0))
  `DWA_ASSERT_NOW(a_granted_useful, clk, rst,
    rsp.valid && (rsp.verdict == VERDICT_GRANTED),
    (rsp.budget_ns >= MinUsefulNs) && (rsp.block_limit != '0))
  `DWA_ASSERT_NEXT(a_stall_parks, clk, rst, in_acc && !advance, skid_v)
  `DWA_ASSERT_NEXT(a_cfg_write, clk, rst, cfg_write,
    quiet_period == $past(pwdata[QuietW-1:0]))

endmodule

`default_nettype wire

### tb/sv/deadline_work_admission_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for deadline_work_admission: a directed table of requests,
// then random requests over several quiet-period settings, results checked in order.
// Depends on dwa_pkg, dwa_if.sv and the deadline_work_admission top level.

module deadline_work_admission_tb;
  import dwa_pkg::*;

  localparam int PIPE_DEPTH      = 4;
  localparam int CYCLE_LIMIT     = 200_000;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 130;

  localparam logic [3:0] ADDR_QUIET_PERIOD = 4'h0;
  localparam logic [2:0] CMD_SPARE_LO      = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI      = 3'd7;

  localparam logic [39:0] QUIET_AT_RESET   = 40'd50_000_000;
  localparam logic [63:0] GUARD_NS         = 64'd250_000;
  localparam logic [63:0] USEFUL_NS        = 64'd100_000;
  localparam logic [62:0] DISPLAY_IDLE_NS  = 63'd100_000_000;
  localparam logic [62:0] GUEST_IDLE_NS    = 63'd20_000_000;
  localparam logic [63:0] DL_MAX_POS       = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] DL_MIN_NEG       = 64'h8000_0000_0000_0000;

  // per-class tables, indexed by class
  localparam logic [63:0] BUDGET_CAP [5] = '{64'd8_000_000, 64'd1_000_000, 64'd8_000_000,
                                             64'd2_000_000, 64'd500_000};
  localparam logic [63:0] RESERVE_FLOOR [5] = '{64'd500_000, 64'd500_000, 64'd500_000,
                                                64'd500_000, 64'd20_000_000};
  localparam logic [8:0]  CLASS_BLOCKS [5] = '{9'd256, 9'd32, 9'd256, 9'd64, 9'd16};
  localparam int          SLACK_SHIFT [5] = '{1, 2, 1, 2, 0};

  typedef struct packed {
    logic [BudgetW-1:0] budget_ns;
    logic [BlocksW-1:0] block_limit;
    verdict_t           verdict;
  } grant_t;

  typedef struct packed {
    req_t   req;
    logic   typed;
    grant_t want;
  } vector_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  dwa_req_if req_ch ();
  dwa_rsp_if rsp_ch ();

  deadline_work_admission dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  grant_t      pending_grants [$];
  logic [39:0] quiet_period;
  int          mismatches    = 0;
  int          results_seen  = 0;
  int          cycles        = 0;
  int          send_idle_pct = 21;
  int          recv_idle_pct = 57;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic grant_t granted(input logic [BudgetW-1:0] budget,
                                     input logic [BlocksW-1:0] blocks);
    grant_t g;
    g.budget_ns   = budget;
    g.block_limit = blocks;
    g.verdict     = VERDICT_GRANTED;
    return g;
  endfunction

  function automatic grant_t refused(input verdict_t v);
    grant_t g;
    g.budget_ns   = '0;
    g.block_limit = '0;
    g.verdict     = v;
    return g;
  endfunction

  // Decision for one request under the given quiet period.
  function automatic grant_t admission_decision(input req_t r, input logic [39:0] quiet);
    cls_t        k;
    logic [63:0] worst;
    logic [63:0] reserve;
    logic [63:0] budget;
    logic [63:0] remaining;
    logic [63:0] slack;
    if (r.mem_pressure) return refused(VERDICT_MEMORY);
    k = (r.command > 3'd4) ? CLS_OFFLINE : cls_t'(r.command);
    if (k == CLS_INTERACTIVE) begin
      if (r.realtime_pending || !r.interaction_quiet_valid ||
          r.interaction_quiet_ns < 63'(quiet))
        return refused(VERDICT_GUEST);
    end else if (k == CLS_OFFLINE) begin
      if (!r.display_live || r.display_quiet_ns < DISPLAY_IDLE_NS)
        return refused(VERDICT_DISPLAY);
      if (!r.deadline_valid && r.guest_idle_ns < GUEST_IDLE_NS)
        return refused(VERDICT_GUEST);
    end
    worst   = (r.compile_p95_ns > r.compile_p99_ns) ? r.compile_p95_ns : r.compile_p99_ns;
    // saturating add of the margin
    reserve = (worst > ~GUARD_NS) ? '1 : worst + GUARD_NS;
    if (reserve < RESERVE_FLOOR[int'(k)]) reserve = RESERVE_FLOOR[int'(k)];
    budget = BUDGET_CAP[int'(k)];
    if (r.deadline_valid) begin
      remaining = r.deadline_left_ns[63] ? 64'd0 : r.deadline_left_ns;
      if (remaining <= reserve) return refused(VERDICT_DEADLINE);
      slack = (remaining - reserve) >> SLACK_SHIFT[int'(k)];
      if (slack < budget) budget = slack;
    end
    if (budget < USEFUL_NS) return refused(VERDICT_ZERO);
    return granted(budget[BudgetW-1:0], CLASS_BLOCKS[int'(k)]);
  endfunction

  function automatic req_t base_request(input cls_t c);
    req_t r;
    r.command                 = c;
    r.mem_pressure            = 1'b0;
    r.compile_p95_ns          = '0;
    r.compile_p99_ns          = '0;
    r.realtime_pending        = 1'b0;
    r.interaction_quiet_valid = 1'b1;
    r.interaction_quiet_ns    = 63'd50_000_000;
    r.display_live            = 1'b1;
    r.display_quiet_ns        = DISPLAY_IDLE_NS;
    r.guest_idle_ns           = GUEST_IDLE_NS;
    r.deadline_valid          = 1'b0;
    r.deadline_left_ns        = '0;
    return r;
  endfunction

  function automatic logic [63:0] random_span();
    logic [63:0] v;
    case ($urandom_range(5))
      0:       v = '0;
      1:       v = 64'($urandom_range(300_000));
      2:       v = 64'($urandom_range(30_000_000));
      3:       v = 64'($urandom);
      4:       v = {$urandom, $urandom};
      default: v = '1 - 64'($urandom_range(300_000));
    endcase
    return v;
  endfunction

  // Mostly well-formed requests, with values clustered about each threshold.
  function automatic req_t random_request(input logic [39:0] quiet);
    req_t        r;
    logic [63:0] worst;
    logic [63:0] dl;
    r.command = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    r.mem_pressure            = ($urandom_range(9) == 0);
    r.compile_p95_ns          = random_span();
    r.compile_p99_ns          = random_span();
    r.realtime_pending        = ($urandom_range(5) == 0);
    r.interaction_quiet_valid = ($urandom_range(7) != 0);
    case ($urandom_range(3))
      0:       r.interaction_quiet_ns = 63'(quiet) + 63'($urandom_range(4)) - 63'd2;
      1:       r.interaction_quiet_ns = 63'({$urandom, $urandom});
      2:       r.interaction_quiet_ns = '0;
      default: r.interaction_quiet_ns = 63'($urandom_range(100_000_000));
    endcase
    r.display_live = ($urandom_range(7) != 0);
    case ($urandom_range(3))
      0:       r.display_quiet_ns = DISPLAY_IDLE_NS - 63'd1 + 63'($urandom_range(2));
      1:       r.display_quiet_ns = DISPLAY_IDLE_NS + 63'($urandom_range(1_000_000_000));
      2:       r.display_quiet_ns = 63'({$urandom, $urandom});
      default: r.display_quiet_ns = 63'($urandom_range(100_000_000));
    endcase
    case ($urandom_range(3))
      0:       r.guest_idle_ns = GUEST_IDLE_NS - 63'd1 + 63'($urandom_range(2));
      1:       r.guest_idle_ns = GUEST_IDLE_NS + 63'($urandom_range(1_000_000_000));
      2:       r.guest_idle_ns = 63'({$urandom, $urandom});
      default: r.guest_idle_ns = 63'($urandom_range(20_000_000));
    endcase
    r.deadline_valid = ($urandom_range(3) != 0);
    worst = (r.compile_p95_ns > r.compile_p99_ns) ? r.compile_p95_ns : r.compile_p99_ns;
    case ($urandom_range(5))
      0:       dl = {$urandom, $urandom};
      1:       dl = worst + GUARD_NS + 64'($urandom_range(20_000_000));
      2:       dl = 64'd500_000 + 64'($urandom_range(20_000_000));
      3:       dl = 64'd20_000_000 + 64'($urandom_range(3_000_000));
      4:       dl = -64'($urandom_range(1_000_000));
      default: dl = worst + GUARD_NS - 64'd1 + 64'($urandom_range(2));
    endcase
    r.deadline_left_ns = dl;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    mismatches++;
    $display("ERROR: result %0d %s: got %0d, want %0d", results_seen, what, got, want);
  endtask

  // Response side: check each accepted item against the oldest expectation.
  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_grants.size() == 0) begin
          flag_mismatch("with nothing expected", 0, 0);
        end else begin
          want = pending_grants.pop_front();
          if (rsp_ch.budget_ns !== want.budget_ns)
            flag_mismatch("budget_ns", rsp_ch.budget_ns, want.budget_ns);
          if (rsp_ch.block_limit !== want.block_limit)
            flag_mismatch("block_limit", rsp_ch.block_limit, want.block_limit);
          if (rsp_ch.verdict !== want.verdict)
            flag_mismatch("verdict", rsp_ch.verdict, want.verdict);
        end
        results_seen++;
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input req_t r, input grant_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid                   <= 1'b1;
    req_ch.command                 <= r.command;
    req_ch.mem_pressure            <= r.mem_pressure;
    req_ch.compile_p95_ns          <= r.compile_p95_ns;
    req_ch.compile_p99_ns          <= r.compile_p99_ns;
    req_ch.realtime_pending        <= r.realtime_pending;
    req_ch.interaction_quiet_valid <= r.interaction_quiet_valid;
    req_ch.interaction_quiet_ns    <= r.interaction_quiet_ns;
    req_ch.display_live            <= r.display_live;
    req_ch.display_quiet_ns        <= r.display_quiet_ns;
    req_ch.guest_idle_ns           <= r.guest_idle_ns;
    req_ch.deadline_valid          <= r.deadline_valid;
    req_ch.deadline_left_ns        <= r.deadline_left_ns;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_grants.push_back(want);
  endtask

  // Only written with the pipeline drained.
  task automatic write_quiet_period(input logic [39:0] value);
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_QUIET_PERIOD;
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    quiet_period = value;
  endtask

  initial begin
    req_t        r;
    vector_t     vectors [$];
    logic [39:0] setting;
    rst     = 1'b1;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    req_ch.valid                   = 1'b0;
    req_ch.command                 = '0;
    req_ch.mem_pressure            = 1'b0;
    req_ch.compile_p95_ns          = '0;
    req_ch.compile_p99_ns          = '0;
    req_ch.realtime_pending        = 1'b0;
    req_ch.interaction_quiet_valid = 1'b0;
    req_ch.interaction_quiet_ns    = '0;
    req_ch.display_live            = 1'b0;
    req_ch.display_quiet_ns        = '0;
    req_ch.guest_idle_ns           = '0;
    req_ch.deadline_valid          = 1'b0;
    req_ch.deadline_left_ns        = '0;
    quiet_period                   = QUIET_AT_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table, run at the reset quiet period
    r = base_request(CLS_ACT_NATIVE); r.mem_pressure = 1'b1;
    vectors.push_back('{r, 1'b1, refused(VERDICT_MEMORY)});
    r = base_request(CLS_ACT_NATIVE);
    vectors.push_back('{r, 1'b1, granted(23'd8_000_000, 9'd256)});
    r = base_request(CLS_INTERACTIVE);
    vectors.push_back('{r, 1'b1, granted(23'd1_000_000, 9'd32)});
    r = base_request(CLS_INTERACTIVE); r.interaction_quiet_ns = 63'd49_999_999;
    vectors.push_back('{r, 1'b1, refused(VERDICT_GUEST)});
    r = base_request(CLS_INTERACTIVE); r.realtime_pending = 1'b1;
    vectors.push_back('{r, 1'b1, refused(VERDICT_GUEST)});
    r = base_request(CLS_INTERACTIVE); r.interaction_quiet_valid = 1'b0;
    vectors.push_back('{r, 1'b1, refused(VERDICT_GUEST)});
    r = base_request(CLS_INTERACTIVE); r.interaction_quiet_ns = '1;
    vectors.push_back('{r, 1'b1, granted(23'd1_000_000, 9'd32)});
    r = base_request(CLS_ACT_PORTABLE);
    vectors.push_back('{r, 1'b1, granted(23'd8_000_000, 9'd256)});
    r = base_request(CLS_PREDICTIVE);
    vectors.push_back('{r, 1'b1, granted(23'd2_000_000, 9'd64)});
    r = base_request(CLS_OFFLINE);
    vectors.push_back('{r, 1'b1, granted(23'd500_000, 9'd16)});
    r = base_request(CLS_OFFLINE); r.display_live = 1'b0;
    vectors.push_back('{r, 1'b1, refused(VERDICT_DISPLAY)});
    r = base_request(CLS_OFFLINE); r.display_quiet_ns = 63'd99_999_999;
    vectors.push_back('{r, 1'b1, refused(VERDICT_DISPLAY)});
    r = base_request(CLS_OFFLINE); r.display_quiet_ns = '0;
    vectors.push_back('{r, 1'b1, refused(VERDICT_DISPLAY)});
    r = base_request(CLS_OFFLINE); r.guest_idle_ns = 63'd19_999_999;
    vectors.push_back('{r, 1'b1, refused(VERDICT_GUEST)});
    r = base_request(CLS_OFFLINE); r.guest_idle_ns = '0;
    vectors.push_back('{r, 1'b1, refused(VERDICT_GUEST)});
    // guest idle is ignored once a deadline is given
    r = base_request(CLS_OFFLINE); r.guest_idle_ns = '0;
    r.deadline_valid = 1'b1; r.deadline_left_ns = DL_MAX_POS;
    vectors.push_back('{r, 1'b1, granted(23'd500_000, 9'd16)});
    r = base_request(CLS_OFFLINE); r.display_quiet_ns = '1; r.guest_idle_ns = '1;
    vectors.push_back('{r, 1'b1, granted(23'd500_000, 9'd16)});
    r = base_request(CLS_OFFLINE); r.command = CMD_SPARE_LO;
    vectors.push_back('{r, 1'b1, granted(23'd500_000, 9'd16)});
    r = base_request(CLS_OFFLINE); r.command = CMD_SPARE_HI; r.display_live = 1'b0;
    vectors.push_back('{r, 1'b1, refused(VERDICT_DISPLAY)});
    r = base_request(CLS_ACT_NATIVE); r.deadline_valid = 1'b1; r.deadline_left_ns = DL_MIN_NEG;
    vectors.push_back('{r, 1'b1, refused(VERDICT_DEADLINE)});
    r = base_request(CLS_ACT_NATIVE); r.deadline_valid = 1'b1; r.deadline_left_ns = 64'd500_000;
    vectors.push_back('{r, 1'b1, refused(VERDICT_DEADLINE)});
    r = base_request(CLS_ACT_NATIVE); r.deadline_valid = 1'b1; r.deadline_left_ns = 64'd500_001;
    vectors.push_back('{r, 1'b1, refused(VERDICT_ZERO)});
    r = base_request(CLS_ACT_NATIVE); r.deadline_valid = 1'b1; r.deadline_left_ns = 64'd700_000;
    vectors.push_back('{r, 1'b0, refused(VERDICT_GRANTED)});
    r = base_request(CLS_ACT_NATIVE); r.deadline_valid = 1'b1; r.deadline_left_ns = DL_MAX_POS;
    vectors.push_back('{r, 1'b1, granted(23'd8_000_000, 9'd256)});
    r = base_request(CLS_ACT_NATIVE); r.compile_p95_ns = '1;
    vectors.push_back('{r, 1'b1, granted(23'd8_000_000, 9'd256)});
    // saturated reserve swallows any deadline
    r = base_request(CLS_PREDICTIVE); r.compile_p99_ns = '1;
    r.deadline_valid = 1'b1; r.deadline_left_ns = DL_MAX_POS;
    vectors.push_back('{r, 1'b1, refused(VERDICT_DEADLINE)});
    r = base_request(CLS_PREDICTIVE); r.compile_p99_ns = 64'd1_000_000;
    r.deadline_valid = 1'b1; r.deadline_left_ns = 64'd1_850_000;
    vectors.push_back('{r, 1'b0, refused(VERDICT_GRANTED)});
    r = base_request(CLS_ACT_NATIVE); r.mem_pressure = 1'b1; r.compile_p95_ns = '1;
    r.deadline_valid = 1'b1; r.deadline_left_ns = DL_MIN_NEG;
    vectors.push_back('{r, 1'b1, refused(VERDICT_MEMORY)});

    foreach (vectors[i])
      send_item(vectors[i].req, vectors[i].typed ? vectors[i].want :
                admission_decision(vectors[i].req, quiet_period));
    req_ch.valid <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       setting = '0;
        1:       setting = '1;
        2:       setting = 40'd1;
        3:       setting = {8'($urandom_range(255)), 32'($urandom)};
        4:       setting = QUIET_AT_RESET;
        default: setting = 40'($urandom_range(200_000_000));
      endcase
      send_idle_pct = (phase < 2) ? 21 : (phase < 4) ? 57 : 0;
      recv_idle_pct = (phase < 2) ? 57 : (phase < 4) ? 21 : 0;
      write_quiet_period(setting);
      repeat (ITEMS_PER_PHASE) begin
        r = random_request(quiet_period);
        send_item(r, admission_decision(r, quiet_period));
      end
      req_ch.valid <= 1'b0;
    end

    while (pending_grants.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/dwa_pkg.sv
hw/rtl/dwa_if.sv
hw/rtl/deadline_work_admission.sv
tb/sv/deadline_work_admission_tb.sv
